### rtl/core/weighted_gram_matrix_core_assert.svh
// Assertion macros for the weighted Gram matrix core.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef WEIGHTED_GRAM_MATRIX_CORE_ASSERT_SVH
`define WEIGHTED_GRAM_MATRIX_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WGM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("weighted Gram matrix core: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("weighted Gram matrix core: assertion failed");

`endif

### rtl/core/wgm_pkg.sv
// Shared constants, types and helpers of the weighted Gram matrix core.
// No dependencies; used by wgm_mac and weighted_gram_matrix_core.
`default_nettype none

package wgm_pkg;

  // Matrix size and derived index widths.
  localparam int MaxCols = 8;
  localparam int ColW    = $clog2(MaxCols);
  localparam int CntW    = $clog2(MaxCols + 1);
  localparam int AddrW   = 2 * ColW;
  localparam int Depth   = 1 << AddrW;

  // Field widths.
  localparam int NColsW = 4;
  localparam int IdxW   = 3;
  localparam int ZW     = 16;
  localparam int WW     = 16;
  localparam int SumW   = 64;
  localparam int ZwW    = ZW + WW + 1;
  localparam int ProdW  = ZwW + ZW;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic load_zw;
    logic issue;
  } mac_ctrl_t;

  // Write-back of one accumulator.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [SumW-1:0]  data;
  } wr_t;

  // Clamp the configured dimension to the range 1 to MaxCols.
  function automatic logic [CntW-1:0] dim_in_use(input logic [NColsW-1:0] n_cols);
    logic [CntW-1:0] n;
    n = CntW'(n_cols);
    if (n_cols == '0) begin
      n = CntW'(1);
    end else if (32'(n_cols) > MaxCols) begin
      n = CntW'(MaxCols);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/core/wgm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module wgm_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/wgm_mac.sv
// Shared multiply-accumulate unit: weight times element, times second element,
// then a saturating add into one accumulator. Depends on wgm_pkg.
`default_nettype none

module wgm_mac
  import wgm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mac_ctrl_t              ctrl_i,
  input  wire logic signed [ZW-1:0]   z_i,
  input  wire logic        [WW-1:0]   w_i,
  input  wire logic        [AddrW-1:0] addr_i,
  input  wire logic                   old_vld_i,
  input  wire logic        [SumW-1:0] rd_data_i,
  output wr_t                         wr_o
);

  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  logic signed [ZwW-1:0]   zw_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    p_vld_q;
  logic        [AddrW-1:0] p_addr_q;
  logic                    p_old_q;
  logic        [SumW-1:0]  old_sum;
  logic        [SumW:0]    sum_ext;

  // First product: row weight times the element of the current row index.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_zw) begin
      zw_q <= $signed(z_i) * $signed({1'b0, w_i});
    end
  end

  // Second product, with the accumulator address and its old-valid flag.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q   <= zw_q * z_i;
      p_addr_q <= addr_i;
      p_old_q  <= old_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= ctrl_i.issue;
    end
  end

  // Saturating add: an accumulator never written since the last clear reads as zero.
  always_comb begin
    old_sum = p_old_q ? rd_data_i : '0;
    sum_ext = {old_sum[SumW-1], old_sum}
            + {{(SumW + 1 - ProdW){prod_q[ProdW-1]}}, prod_q};
    wr_o.en   = p_vld_q;
    wr_o.addr = p_addr_q;
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      wr_o.data = sum_ext[SumW] ? SumMin : SumMax;
    end else begin
      wr_o.data = sum_ext[SumW-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/weighted_gram_matrix_core.sv
// Top level of the weighted Gram matrix core: sequencer, row store and valid bits.
// Depends on wgm_pkg, wgm_ram, wgm_mac and weighted_gram_matrix_core_assert.svh.
`default_nettype none

// Accumulates Z'diag(w)Z over rows of n_cols signed Q4.12 elements, one element per
// start pulse, and emits the upper triangle (38 fractional bits, saturated) when an
// element carries end_of_data. An element that neither completes a row nor carries
// end_of_data leaves busy low. An element that carries end_of_data
// without completing a row drops the partial row and goes straight to the emission.
// The element that completes a row runs one weight-product step (ST_ZW) per row index
// and one step of the single multiply-accumulate unit (ST_MUL) per triangle entry,
// then a drain step (ST_DRAIN) to finish the last write-back. An emission then steps
// through the triangle entries (ST_EMIT) and a final state (ST_LAST); results appear
// one per cycle on consecutive cycles, marked by res_strobe_o, and the receiver cannot
// stall them. The accumulators need no clearing pass: a valid bit per entry is cleared
// at reset and after each emission.
module weighted_gram_matrix_core
  import wgm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [ZW-1:0]   z_value_i,
  input  wire logic        [WW-1:0]   weight_i,
  input  wire logic                   end_of_data_i,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic        [NColsW-1:0] cfg_n_cols_i,
  output logic                        res_strobe_o,
  output logic             [IdxW-1:0] row_index_o,
  output logic             [IdxW-1:0] col_index_o,
  output logic signed      [SumW-1:0] sum_value_o,
  output logic                        last_o
);

  `include "weighted_gram_matrix_core_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ZW    = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [NColsW-1:0] n_cols_q;
  logic [ColW-1:0]   cc_q, cc_d;
  logic [ColW-1:0]   r_q, r_d;
  logic [ColW-1:0]   c_q, c_d;
  logic [WW-1:0]     w_q, w_d;
  logic              eod_q, eod_d;
  logic [ZW-1:0]     row_store_q [MaxCols];
  logic [Depth-1:0]  valid_q;

  logic [CntW-1:0]   n_use;
  logic              row_done;
  logic              r_last;
  logic              c_last;
  logic              rs_we;
  logic              emit;
  logic              clr_valid;
  logic [ColW-1:0]   rs_addr;
  logic [AddrW-1:0]  rd_addr;
  logic              rd_en;
  logic [SumW-1:0]   rd_data;
  mac_ctrl_t         mac_ctrl;
  wr_t               mac_wr;

  logic              out_strobe_q;
  logic [IdxW-1:0]   out_row_q;
  logic [IdxW-1:0]   out_col_q;
  logic              out_last_q;
  logic              out_vld_q;

  // Dimension in use and loop limits.
  assign n_use    = dim_in_use(n_cols_q);
  assign row_done = (CntW'(cc_q) + CntW'(1)) >= n_use;
  assign r_last   = CntW'(r_q) == (n_use - CntW'(1));
  assign c_last   = CntW'(c_q) == (n_use - CntW'(1));

  assign busy        = state_q != ST_IDLE;
  assign cfg_ready_o = !busy;

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cc_d      = cc_q;
    r_d       = r_q;
    c_d       = c_q;
    w_d       = w_q;
    eod_d     = eod_q;
    rs_we     = 1'b0;
    emit      = 1'b0;
    clr_valid = 1'b0;
    mac_ctrl  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          rs_we = 1'b1;
          w_d   = weight_i;
          eod_d = end_of_data_i;
          if (row_done) begin
            cc_d    = '0;
            r_d     = '0;
            state_d = ST_ZW;
          end else if (end_of_data_i) begin
            // A partial row is dropped.
            cc_d    = '0;
            r_d     = '0;
            c_d     = '0;
            state_d = ST_EMIT;
          end else begin
            cc_d = cc_q + ColW'(1);
          end
        end
      end
      ST_ZW: begin
        mac_ctrl.load_zw = 1'b1;
        c_d              = r_q;
        state_d          = ST_MUL;
      end
      ST_MUL: begin
        mac_ctrl.issue = 1'b1;
        if (c_last) begin
          if (r_last) begin
            state_d = ST_DRAIN;
          end else begin
            r_d     = r_q + ColW'(1);
            state_d = ST_ZW;
          end
        end else begin
          c_d = c_q + ColW'(1);
        end
      end
      ST_DRAIN: begin
        if (eod_q) begin
          r_d     = '0;
          c_d     = '0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        emit = 1'b1;
        if (c_last) begin
          if (r_last) begin
            state_d = ST_LAST;
          end else begin
            r_d = r_q + ColW'(1);
            c_d = r_q + ColW'(1);
          end
        end else begin
          c_d = c_q + ColW'(1);
        end
      end
      ST_LAST: begin
        clr_valid = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_cols_q <= NColsW'(MaxCols);
      cc_q     <= '0;
      r_q      <= '0;
      c_q      <= '0;
      eod_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      r_q     <= r_d;
      c_q     <= c_d;
      eod_q   <= eod_d;
      if (cfg_valid_i && cfg_ready_o) begin
        n_cols_q <= cfg_n_cols_i;
      end
    end
  end

  // Row weight and the elements of the current row.
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (rs_we) begin
      row_store_q[cc_q] <= z_value_i;
    end
  end

  // One row store read per cycle: the row element for the weight product, else the column.
  assign rs_addr = (state_q == ST_ZW) ? r_q : c_q;
  assign rd_addr = {r_q, c_q};
  assign rd_en   = (state_q == ST_MUL) || emit;

  // Accumulator valid bits stand in for clearing the accumulator memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_valid) begin
      valid_q <= '0;
    end else if (mac_wr.en) begin
      valid_q[mac_wr.addr] <= 1'b1;
    end
  end

  wgm_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .z_i       ($signed(row_store_q[rs_addr])),
    .w_i       (w_q),
    .addr_i    (rd_addr),
    .old_vld_i (valid_q[rd_addr]),
    .rd_data_i (rd_data),
    .wr_o      (mac_wr)
  );

  wgm_ram #(
    .Width (SumW),
    .Depth (Depth)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (mac_wr.en),
    .waddr_i (mac_wr.addr),
    .wdata_i (mac_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Result stage, aligned with the registered memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_strobe_q <= 1'b0;
    end else begin
      out_strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q  <= IdxW'(r_q);
      out_col_q  <= IdxW'(c_q);
      out_last_q <= r_last && c_last;
      out_vld_q  <= valid_q[rd_addr];
    end
  end

  assign res_strobe_o = out_strobe_q;
  assign row_index_o  = out_row_q;
  assign col_index_o  = out_col_q;
  assign last_o       = out_last_q;
  assign sum_value_o  = out_vld_q ? $signed(rd_data) : '0;

  // Results are only shown while the block is busy.
  `WGM_ASSERT_SAME(a_strobe_busy, res_strobe_o, busy)
  // An emission runs without gaps until its last entry.
  `WGM_ASSERT_NEXT(a_emit_contiguous, res_strobe_o && !last_o, res_strobe_o)
  // The block is ready again right after the last entry.
  `WGM_ASSERT_NEXT(a_last_frees, res_strobe_o && last_o, !busy && !res_strobe_o)
  // Accumulator write-backs happen only during the accumulation pass.
  `WGM_ASSERT_SAME(a_wb_in_pass, mac_wr.en,
                   state_q == ST_ZW || state_q == ST_MUL || state_q == ST_DRAIN)

endmodule

`default_nettype wire
